[src/mnp_pkg.sv]
// ----------------------------------------------------------------------------
// mnp_pkg - MIDI note parser shared definitions
// Status codes, event kinds and octave geometry used by the parser and its
// checker.
// ----------------------------------------------------------------------------
package mnp_pkg;

    localparam int unsigned NOTES_PER_OCTAVE = 12;

    localparam logic [3:0] STATUS_NOTE_OFF = 4'h8;   // upper nibble
    localparam logic [3:0] STATUS_NOTE_ON  = 4'h9;
    localparam logic [7:0] STATUS_REALTIME = 8'hF8;

    localparam logic EV_NOTE_OFF = 1'b0;
    localparam logic EV_NOTE_ON  = 1'b1;

    localparam logic CFG_CHANNEL = 1'b0;
    localparam logic CFG_OCTAVE  = 1'b1;

    // first note of an octave: 12 + 12*octave, at most 192
    function automatic logic [7:0] octave_start(input logic [3:0] oct);
        logic [7:0] o8;
        o8 = {4'd0, oct};
        return (o8 << 3) + (o8 << 2) + 8'(NOTES_PER_OCTAVE);
    endfunction

endpackage

[src/midi_note_message_parser.sv]
// ----------------------------------------------------------------------------
// midi_note_message_parser - MIDI Note On / Note Off parser
// Picks Note On and Note Off messages for one channel and one octave out of a
// stream of received MIDI bytes.
// ----------------------------------------------------------------------------
// One MIDI byte is taken per request on the input channel, and a new byte can
// be taken in every cycle unless the output register is stalled. Each byte
// passes an input register, one parse stage and an output register; the
// single parse stage updating the message state sets the rate of one byte per
// cycle while the output is not stalled. Note Off gives its key index as soon
// as the note byte arrives (velocity reads zero); Note On gives key and
// velocity after the velocity byte. Real-time bytes (0xF8 and above) are
// ignored, any other non-matching status byte abandons a pending message, and
// running status is not supported. Channel and octave are written through the
// configuration port (index 0 channel, index 1 octave); the user must write
// them only while the block is idle, and the block does not enforce this.
module midi_note_message_parser
    import mnp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [3:0] i_cfg_data,
    // byte input
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_midi_byte,
    // event output
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_event_kind,
    output logic [3:0] o_key_index,
    output logic [6:0] o_velocity
);

    // parse phases; the spare code behaves as waiting for status
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_NOTE = 2'd1;
    localparam logic [1:0] PH_VEL  = 2'd2;

    // configuration registers
    logic [3:0] r_channel;
    logic [3:0] r_octave;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // message state
    logic [1:0] r_phase,   n_phase;
    logic       r_pend_on, n_pend_on;
    logic [3:0] r_pend_key, n_pend_key;

    // output register
    logic       r_out_valid;
    logic       r_out_kind;
    logic [3:0] r_out_key;
    logic [6:0] r_out_vel;

    logic       n_res;
    logic       n_res_kind;
    logic [3:0] n_res_key;
    logic [6:0] n_res_vel;

    logic       advance;
    logic       process;
    logic [8:0] start;
    logic [8:0] diff;
    logic       in_octave;

    // the parse stage moves whenever the output register is free or draining
    assign advance    = !r_out_valid || i_out_ready;
    assign process    = r_in_valid && advance;
    assign o_in_ready = !r_in_valid || advance;

    assign start     = {1'b0, octave_start(r_octave)};
    assign diff      = {1'b0, r_in_byte} - start;
    assign in_octave = ({1'b0, r_in_byte} >= start) &&
                       (diff < 9'(NOTES_PER_OCTAVE));

    always_comb begin
        n_phase    = r_phase;
        n_pend_on  = r_pend_on;
        n_pend_key = r_pend_key;
        n_res      = 1'b0;
        n_res_kind = EV_NOTE_OFF;
        n_res_key  = diff[3:0];
        n_res_vel  = 7'd0;
        if (r_in_byte inside {[STATUS_REALTIME:8'hFF]}) begin
            // real-time: no effect at all
        end else if (r_in_byte[7]) begin
            if (r_in_byte == {STATUS_NOTE_OFF, r_channel}) begin
                n_phase   = PH_NOTE;
                n_pend_on = 1'b0;
            end else if (r_in_byte == {STATUS_NOTE_ON, r_channel}) begin
                n_phase   = PH_NOTE;
                n_pend_on = 1'b1;
            end else begin
                n_phase = PH_IDLE;
            end
        end else begin
            case (r_phase)
                PH_NOTE: begin
                    n_phase = PH_IDLE;
                    if (in_octave) begin
                        if (r_pend_on) begin
                            n_pend_key = diff[3:0];
                            n_phase    = PH_VEL;
                        end else begin
                            n_res = 1'b1;
                        end
                    end
                end
                PH_VEL: begin
                    n_phase    = PH_IDLE;
                    n_res      = 1'b1;
                    n_res_kind = EV_NOTE_ON;
                    n_res_key  = r_pend_key;
                    n_res_vel  = r_in_byte[6:0];
                end
                default: begin
                    n_phase = PH_IDLE;   // stray data byte
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel   <= 4'd0;
            r_octave    <= 4'd0;
            r_in_valid  <= 1'b0;
            r_phase     <= PH_IDLE;
            r_pend_on   <= 1'b0;
            r_pend_key  <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_CHANNEL) begin
                    r_channel <= i_cfg_data;
                end else begin
                    r_octave <= i_cfg_data;
                end
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (process) begin
                r_phase    <= n_phase;
                r_pend_on  <= n_pend_on;
                r_pend_key <= n_pend_key;
            end
            if (advance) begin
                r_out_valid <= process && n_res;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_midi_byte;
        end
        if (process && n_res) begin
            r_out_kind <= n_res_kind;
            r_out_key  <= n_res_key;
            r_out_vel  <= n_res_vel;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_event_kind = r_out_kind;
    assign o_key_index  = r_out_key;
    assign o_velocity   = r_out_vel;

endmodule

[src/mnp_checker.sv]
// ----------------------------------------------------------------------------
// mnp_checker - port checks for the MIDI note parser
// Watches the top level ports and flags malformed or unstable events.
// ----------------------------------------------------------------------------
module mnp_checker
    import mnp_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_event_kind,
    input logic [3:0] o_key_index,
    input logic [6:0] o_velocity
);

    // no event survives reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("event valid after reset");

    // note off carries no velocity
    a_off_no_vel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_kind == EV_NOTE_OFF) |-> o_velocity == 7'd0)
        else $error("note off with nonzero velocity");

    // key lies within one octave
    a_key_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_key_index < 4'(NOTES_PER_OCTAVE))
        else $error("key index out of octave");

    // a stalled event holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_event_kind) && $stable(o_key_index)
            && $stable(o_velocity))
        else $error("stalled event changed");

endmodule

bind midi_note_message_parser mnp_checker u_mnp_checker (.*);

[tb/sv/midi_note_message_parser_tb.sv]
// ----------------------------------------------------------------------------
// midi_note_message_parser_tb - self-checking bench for the MIDI note parser
// Sends MIDI byte streams through the input channel and tracks the parse
// state alongside the block. Each note event that comes out is checked field
// by field against the oldest predicted event. Directed streams come first,
// then random traffic under several idle and stall patterns.
// ----------------------------------------------------------------------------
module midi_note_message_parser_tb;
    import mnp_pkg::*;

    // one expected note event
    typedef struct packed {
        logic       kind;
        logic [3:0] key;
        logic [6:0] vel;
    } t_note_event;

    // where the parser is within a note message
    typedef enum logic [1:0] {
        PH_WAIT_STATUS,
        PH_WAIT_NOTE,
        PH_WAIT_VEL
    } t_parse_phase;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic       i_cfg_index = CFG_CHANNEL;
    logic [3:0] i_cfg_data  = 4'd0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_ready;
    logic [7:0] i_midi_byte = 8'd0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic       o_event_kind;
    logic [3:0] o_key_index;
    logic [6:0] o_velocity;

    // tracked copy of the parser's registers and state
    logic [3:0]   cfg_channel = 4'd0;
    logic [3:0]   cfg_octave  = 4'd0;
    t_parse_phase phase       = PH_WAIT_STATUS;
    logic         held_is_on  = 1'b0;
    logic [3:0]   held_key    = 4'd0;

    t_note_event expected_notes[$];
    int unsigned mismatches      = 0;
    int unsigned bytes_sent      = 0;
    int unsigned byte_gap_pct    = 0;   // chance of an idle cycle before each request
    int unsigned event_stall_pct = 0;   // chance the event side holds ready low

    midi_note_message_parser dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_midi_byte  (i_midi_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_event_kind (o_event_kind),
        .o_key_index  (o_key_index),
        .o_velocity   (o_velocity)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // hard stop well past the slowest legal run
    initial begin
        #3600000;
        $display("midi_note_message_parser_tb NOT OK");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        mismatches++;
    endtask

    // Works out what one accepted byte does to the parse state and which
    // event, if any, it completes.
    function automatic void parse_midi_byte(input logic [7:0] b);
        int unsigned lo;
        lo = NOTES_PER_OCTAVE * (int'(cfg_octave) + 1);
        if (b >= STATUS_REALTIME)
            return;                         // real-time: invisible to the parser
        if (b[7]) begin
            if (b == {STATUS_NOTE_OFF, cfg_channel}) begin
                phase      = PH_WAIT_NOTE;
                held_is_on = 1'b0;
            end else if (b == {STATUS_NOTE_ON, cfg_channel}) begin
                phase      = PH_WAIT_NOTE;
                held_is_on = 1'b1;
            end else begin
                phase = PH_WAIT_STATUS;     // any other status drops the message
            end
            return;
        end
        case (phase)
            PH_WAIT_NOTE: begin
                // octaves 10..15 start above 127, so nothing matches there
                if (b >= lo && b < lo + NOTES_PER_OCTAVE) begin
                    if (held_is_on) begin
                        held_key = 4'(b - lo);
                        phase    = PH_WAIT_VEL;
                    end else begin
                        expected_notes.push_back('{EV_NOTE_OFF, 4'(b - lo), 7'd0});
                        phase = PH_WAIT_STATUS;
                    end
                end else begin
                    phase = PH_WAIT_STATUS;
                end
            end
            PH_WAIT_VEL: begin
                expected_notes.push_back('{EV_NOTE_ON, held_key, b[6:0]});
                phase = PH_WAIT_STATUS;
            end
            default: phase = PH_WAIT_STATUS;  // stray data byte
        endcase
    endfunction

    // One request on the byte channel. Valid is only ever lowered here when a gap
    // is taken.
    task automatic send_byte(input logic [7:0] b);
        while (byte_gap_pct != 0 && $urandom_range(99) < byte_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_midi_byte <= b;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        parse_midi_byte(b);
        bytes_sent++;
    endtask

    // Stops sending, lets every predicted event drain, then waits out the input
    // register, parse stage and output register so a byte with no event cannot still be in flight.
    task automatic settle_parser();
        int unsigned waited;
        waited = 0;
        i_in_valid <= 1'b0;
        while (expected_notes.size() != 0 && waited < 4000) begin
            @(posedge i_clk);
            waited++;
        end
        if (expected_notes.size() != 0) begin
            report_mismatch($sformatf("%0d expected event(s) never arrived",
                                      expected_notes.size()));
            expected_notes.delete();
        end
        repeat (8) @(posedge i_clk);
    endtask

    // Only called with the parser settled. The enable drops after each write so
    // back-to-back writes stay apart.
    task automatic write_register(input logic idx, input logic [3:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_CHANNEL)
            cfg_channel = val;
        else
            cfg_octave = val;
        @(posedge i_clk);
    endtask

    task automatic maybe_realtime();
        if ($urandom_range(9) == 0)
            send_byte(8'($urandom_range(8'hFF, 8'hF8)));
    endtask

    // Mostly well-formed note messages for the current channel and octave,
    // with noise and cut-short messages mixed in.
    task automatic send_note_message();
        int unsigned pick;
        int unsigned note;
        int unsigned lo;
        logic        on;
        pick = $urandom_range(99);
        lo   = NOTES_PER_OCTAVE * (int'(cfg_octave) + 1);
        if (pick < 75) begin
            on = 1'($urandom_range(1));
            send_byte({on ? STATUS_NOTE_ON : STATUS_NOTE_OFF, cfg_channel});
            maybe_realtime();
            if ($urandom_range(99) < 85)
                note = lo + $urandom_range(NOTES_PER_OCTAVE - 1);
            else
                note = $urandom_range(127);
            if (note > 127)
                note = $urandom_range(127);
            send_byte(note[7:0]);
            if (on) begin
                maybe_realtime();
                send_byte({1'b0, 7'($urandom_range(127))});
            end
        end else if (pick < 85) begin
            send_byte(8'($urandom));
        end else if (pick < 93) begin
            // status of another kind (0xA0..0xEF) with a data byte behind it
            send_byte({1'b1, 3'($urandom_range(6, 2)), 4'($urandom)});
            send_byte(8'($urandom_range(127)));
        end else begin
            // note message cut short by one for the neighbouring channel
            send_byte({STATUS_NOTE_ON, cfg_channel});
            send_byte({STATUS_NOTE_ON, 4'(cfg_channel + 4'd1)});
            send_byte(8'(lo + $urandom_range(NOTES_PER_OCTAVE - 1)));
        end
    endtask

    // Event side: random back-pressure and the in-order check.
    always @(posedge i_clk) begin : event_checker
        t_note_event want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            if (expected_notes.size() == 0) begin
                report_mismatch($sformatf("unexpected event kind=%0b key=%0d vel=%0d",
                                          o_event_kind, o_key_index, o_velocity));
            end else begin
                want = expected_notes.pop_front();
                if (o_event_kind !== want.kind)
                    report_mismatch($sformatf("event_kind %0b, expected %0b",
                                              o_event_kind, want.kind));
                if (o_key_index !== want.key)
                    report_mismatch($sformatf("key_index %0d, expected %0d",
                                              o_key_index, want.key));
                if (o_velocity !== want.vel)
                    report_mismatch($sformatf("velocity %0d, expected %0d",
                                              o_velocity, want.vel));
            end
        end
        i_out_ready <= ($urandom_range(99) >= event_stall_pct);
    end

    // Reset values: channel 0, octave 0, so notes 12..23 are live.
    task automatic test_note_range_edges();
        send_byte({STATUS_NOTE_OFF, 4'd0});
        send_byte(8'd12);                       // lowest key, off
        send_byte({STATUS_NOTE_ON, 4'd0});
        send_byte(8'd23);                       // highest key
        send_byte(8'd127);                      // top velocity
        send_byte({STATUS_NOTE_ON, 4'd0});
        send_byte(8'd11);                       // just below the octave
        send_byte({STATUS_NOTE_OFF, 4'd0});
        send_byte(8'd24);                       // just above
        settle_parser();
    endtask

    task automatic test_status_handling();
        // real-time bytes inside a message change nothing; velocity zero
        send_byte({STATUS_NOTE_ON, 4'd0});
        send_byte(STATUS_REALTIME);
        send_byte(8'd15);
        send_byte(8'hFF);
        send_byte(8'd0);
        // system status abandons the pending note, velocity byte then stray
        send_byte({STATUS_NOTE_ON, 4'd0});
        send_byte(8'd14);
        send_byte(8'hF0);
        send_byte(8'd64);
        // no running status: the second note byte is stray
        send_byte({STATUS_NOTE_OFF, 4'd0});
        send_byte(8'd13);
        send_byte(8'd14);
        settle_parser();
    endtask

    task automatic test_config_extremes();
        write_register(CFG_CHANNEL, 4'd15);
        write_register(CFG_OCTAVE, 4'd9);       // notes 120..131, only 120..127 exist
        send_byte({STATUS_NOTE_OFF, 4'd15});
        send_byte(8'd120);
        send_byte({STATUS_NOTE_ON, 4'd15});
        send_byte(8'd127);
        send_byte(8'd1);
        send_byte({STATUS_NOTE_OFF, 4'd0});     // old channel now ignored
        send_byte(8'd120);
        settle_parser();
        write_register(CFG_OCTAVE, 4'd15);      // range beyond 127: nothing passes
        send_byte({STATUS_NOTE_ON, 4'd15});
        send_byte(8'd127);
        settle_parser();
    endtask

    // Channel is taken at the status byte, octave at the note byte.
    task automatic test_writes_mid_message();
        send_byte({STATUS_NOTE_ON, 4'd15});
        settle_parser();
        write_register(CFG_CHANNEL, 4'd3);
        write_register(CFG_OCTAVE, 4'd0);
        send_byte(8'd12);
        send_byte(8'd77);
        settle_parser();
    endtask

    task automatic test_random_traffic(input int unsigned gap_pct,
                                       input int unsigned stall_pct);
        int unsigned pick;
        int unsigned block_start;
        byte_gap_pct    = gap_pct;
        event_stall_pct = stall_pct;
        repeat (4) begin
            pick = $urandom_range(99);
            write_register(CFG_CHANNEL, pick < 25 ? 4'd0 :
                                        pick < 50 ? 4'd15 : 4'($urandom));
            pick = $urandom_range(99);
            write_register(CFG_OCTAVE, pick < 20 ? 4'd0 :
                                       pick < 40 ? 4'd9 :
                                       pick < 45 ? 4'($urandom_range(15, 10)) :
                                                   4'($urandom_range(9)));
            block_start = bytes_sent;
            while (bytes_sent - block_start < 40)
                send_note_message();
            settle_parser();
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_note_range_edges();
        test_status_handling();
        test_config_extremes();
        test_writes_mid_message();

        test_random_traffic(0, 0);              // back to back
        test_random_traffic(51, 0);             // sparse requests
        test_random_traffic(0, 51);             // heavy back-pressure
        test_random_traffic(12, 12);            // a bit of both

        settle_parser();
        if (mismatches == 0) begin
            $display("midi_note_message_parser_tb OK");
        end else begin
            $display("midi_note_message_parser_tb NOT OK");
        end
        $finish;
    end

endmodule
